// ----- src/wfgd_pkg.sv -----
// Shared types, constants and a helper function of the wait-for graph deadlock detector.
package wfgd_pkg;

  localparam int MaxNodes = 16;
  localparam int NodeW    = $clog2(MaxNodes);
  localparam int CntW     = $clog2(MaxNodes + 1);

  typedef logic [NodeW-1:0]    node_t;
  typedef logic [CntW-1:0]     cnt_t;
  typedef logic [MaxNodes-1:0] row_t;

  typedef enum logic [1:0] {
    StStored   = 2'd0,
    StRejected = 2'd1,
    StClear    = 2'd2,
    StDeadlock = 2'd3
  } status_e;

  typedef struct packed {
    logic done;
    logic deadlock;
  } dfs_stat_t;

  // Index of the lowest set bit; zero when no bit is set.
  function automatic node_t find_first(input row_t vec);
    node_t idx;
    idx = '0;
    for (int k = MaxNodes - 1; k >= 0; k--) begin
      if (vec[k]) begin
        idx = node_t'(k);
      end
    end
    return idx;
  endfunction

endpackage

// ----- src/wait_for_graph_deadlock_detect_unit.sv -----
// Top level of the wait-for graph deadlock detector: handshake, edge insertion, result register.
//
// Input beats carry req_type_i, from_node_i and to_node_i under in_valid_i / in_ready_o;
// every input beat yields exactly one output beat on status_o under out_valid_o / out_ready_i.
// An add-edge beat is range checked against num_nodes; a rejected edge goes straight to
// S_RESP, a stored edge does a read-modify-write of its adjacency row in S_ADD_WR and
// then answers. A check beat runs a depth-first search over the adjacency memory: each
// root is tried in a D_ROOT step, and each edge examined and each pop is decided in a D_EVAL
// step, which follows a D_READ step that waits for the registered row memory read.
// One request is in flight at a time, and a new beat is taken as soon as the previous
// result sits in the output register, even while the receiver stalls it.
// cfg_we_i writes num_nodes from cfg_wdata_i; values above 16 act as 16. Write it only
// while no request is outstanding.
// Reset clears the graph through per-row valid bits, sets num_nodes to 16 and empties
// the output register; the block is ready as soon as reset is released.
module wait_for_graph_deadlock_detect_unit (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  req_type_i,
  input  logic [3:0]            from_node_i,
  input  logic [3:0]            to_node_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [1:0]            status_o,
  input  logic                  cfg_we_i,
  input  logic [4:0]            cfg_wdata_i
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ADD_WR,
    S_CHECK,
    S_RESP
  } top_state_e;

  top_state_e          state_q;
  logic [4:0]          num_nodes_q;
  wfgd_pkg::status_e   resp_q;
  wfgd_pkg::status_e   status_q;
  logic                out_valid_q;
  wfgd_pkg::node_t     from_q;
  wfgd_pkg::node_t     to_q;

  wfgd_pkg::cnt_t      n_eff;
  logic                in_acc;
  logic                reject;
  logic                out_load;
  logic                ram_we;
  wfgd_pkg::node_t     ram_rd_addr;
  wfgd_pkg::row_t      ram_rd_data;
  wfgd_pkg::row_t      ram_wr_data;
  wfgd_pkg::node_t     dfs_rd_addr;
  wfgd_pkg::dfs_stat_t dfs_stat;

  assign n_eff = (num_nodes_q > 5'(wfgd_pkg::MaxNodes)) ? wfgd_pkg::CntW'(wfgd_pkg::MaxNodes)
                                                        : wfgd_pkg::CntW'(num_nodes_q);
  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign reject      = (wfgd_pkg::CntW'(from_node_i) >= n_eff)
                       || (wfgd_pkg::CntW'(to_node_i) >= n_eff);
  assign out_load    = (state_q == S_RESP) && (!out_valid_q || out_ready_i);
  assign ram_we      = (state_q == S_ADD_WR);
  assign ram_rd_addr = (state_q == S_CHECK) ? dfs_rd_addr : from_node_i;
  assign ram_wr_data = ram_rd_data | (wfgd_pkg::row_t'(1) << to_q);
  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;

  wfgd_adj_ram u_adj_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_addr_i (ram_rd_addr),
    .rd_data_o (ram_rd_data),
    .we_i      (ram_we),
    .wr_addr_i (from_q),
    .wr_data_i (ram_wr_data)
  );

  wfgd_dfs u_dfs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (in_acc && req_type_i),
    .num_nodes_i (n_eff),
    .rd_addr_o   (dfs_rd_addr),
    .rd_data_i   (ram_rd_data),
    .stat_o      (dfs_stat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_nodes_q <= 5'(wfgd_pkg::MaxNodes);
    end else if (cfg_we_i) begin
      num_nodes_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      from_q <= from_node_i;
      to_q   <= to_node_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      resp_q      <= wfgd_pkg::StStored;
      status_q    <= wfgd_pkg::StStored;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            if (req_type_i) begin
              state_q <= S_CHECK;
            end else if (reject) begin
              resp_q  <= wfgd_pkg::StRejected;
              state_q <= S_RESP;
            end else begin
              state_q <= S_ADD_WR;
            end
          end
        end
        S_ADD_WR: begin
          resp_q  <= wfgd_pkg::StStored;
          state_q <= S_RESP;
        end
        S_CHECK: begin
          if (dfs_stat.done) begin
            resp_q  <= dfs_stat.deadlock ? wfgd_pkg::StDeadlock : wfgd_pkg::StClear;
            state_q <= S_RESP;
          end
        end
        S_RESP: begin
          if (out_load) begin
            status_q <= resp_q;
            state_q  <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- src/wfgd_adj_ram.sv -----
// Adjacency row memory with per-row valid bits and a registered read port.
module wfgd_adj_ram (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  wfgd_pkg::node_t rd_addr_i,
  output wfgd_pkg::row_t  rd_data_o,
  input  logic            we_i,
  input  wfgd_pkg::node_t wr_addr_i,
  input  wfgd_pkg::row_t  wr_data_i
);

  wfgd_pkg::row_t mem [wfgd_pkg::MaxNodes];
  logic [wfgd_pkg::MaxNodes-1:0] row_vld_q;
  wfgd_pkg::row_t rd_data_q;
  logic           rd_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
    end else if (we_i) begin
      row_vld_q[wr_addr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem[rd_addr_i];
    rd_vld_q  <= row_vld_q[rd_addr_i];
  end

  assign rd_data_o = rd_vld_q ? rd_data_q : '0;

endmodule

// ----- src/wfgd_dfs.sv -----
// Depth-first search engine with an explicit path stack over the adjacency memory.
module wfgd_dfs (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  wfgd_pkg::cnt_t      num_nodes_i,
  output wfgd_pkg::node_t     rd_addr_o,
  input  wfgd_pkg::row_t      rd_data_i,
  output wfgd_pkg::dfs_stat_t stat_o
);

  typedef enum logic [1:0] {
    D_IDLE,
    D_ROOT,
    D_READ,
    D_EVAL
  } dfs_state_e;

  dfs_state_e          state_q;
  wfgd_pkg::cnt_t      root_q;
  wfgd_pkg::cnt_t      depth_q;
  wfgd_pkg::row_t      visited_q;
  wfgd_pkg::row_t      on_path_q;
  wfgd_pkg::dfs_stat_t stat_q;

  wfgd_pkg::node_t stk_node_q [wfgd_pkg::MaxNodes];
  wfgd_pkg::cnt_t  stk_next_q [wfgd_pkg::MaxNodes];

  wfgd_pkg::cnt_t  top_full;
  wfgd_pkg::node_t top;
  wfgd_pkg::node_t top_node;
  wfgd_pkg::cnt_t  top_next;
  wfgd_pkg::node_t push_idx;
  wfgd_pkg::node_t root_node;
  wfgd_pkg::row_t  cand;
  wfgd_pkg::node_t nxt;
  logic            push_root;
  logic            push_nxt;
  logic            adv_top;
  logic            fin_clear;
  logic            fin_dead;

  assign top_full  = depth_q - wfgd_pkg::CntW'(1);
  assign top       = top_full[wfgd_pkg::NodeW-1:0];
  assign top_node  = stk_node_q[top];
  assign top_next  = stk_next_q[top];
  assign push_idx  = depth_q[wfgd_pkg::NodeW-1:0];
  assign root_node = root_q[wfgd_pkg::NodeW-1:0];

  always_comb begin
    for (int k = 0; k < wfgd_pkg::MaxNodes; k++) begin
      cand[k] = rd_data_i[k] && (wfgd_pkg::CntW'(k) < num_nodes_i)
                && (wfgd_pkg::CntW'(k) >= top_next);
    end
  end

  assign nxt       = wfgd_pkg::find_first(cand);
  assign push_root = (state_q == D_ROOT) && (root_q < num_nodes_i) && !visited_q[root_node];
  assign adv_top   = (state_q == D_EVAL) && (cand != '0);
  assign push_nxt  = adv_top && !visited_q[nxt];
  assign fin_clear = (state_q == D_ROOT) && (root_q >= num_nodes_i);
  assign fin_dead  = adv_top && !push_nxt && on_path_q[nxt];
  assign rd_addr_o = top_node;
  assign stat_o    = stat_q;

  always_ff @(posedge clk_i) begin
    if (adv_top) begin
      stk_next_q[top] <= wfgd_pkg::CntW'(nxt) + wfgd_pkg::CntW'(1);
    end
    if (push_root) begin
      stk_node_q[push_idx] <= root_node;
      stk_next_q[push_idx] <= '0;
    end else if (push_nxt) begin
      stk_node_q[push_idx] <= nxt;
      stk_next_q[push_idx] <= '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= D_IDLE;
      root_q    <= '0;
      depth_q   <= '0;
      visited_q <= '0;
      on_path_q <= '0;
      stat_q    <= '0;
    end else begin
      stat_q <= '{done: fin_clear || fin_dead, deadlock: fin_dead};
      unique case (state_q)
        D_IDLE: begin
          if (start_i) begin
            visited_q <= '0;
            on_path_q <= '0;
            depth_q   <= '0;
            root_q    <= '0;
            state_q   <= D_ROOT;
          end
        end
        D_ROOT: begin
          if (root_q >= num_nodes_i) begin
            state_q <= D_IDLE;
          end else begin
            root_q <= root_q + wfgd_pkg::CntW'(1);
            if (push_root) begin
              visited_q[root_node] <= 1'b1;
              on_path_q[root_node] <= 1'b1;
              depth_q              <= depth_q + wfgd_pkg::CntW'(1);
              state_q              <= D_READ;
            end
          end
        end
        D_READ: begin
          state_q <= D_EVAL;
        end
        D_EVAL: begin
          if (!adv_top) begin
            on_path_q[top_node] <= 1'b0;
            depth_q             <= top_full;
            state_q             <= (top_full == '0) ? D_ROOT : D_READ;
          end else if (push_nxt) begin
            visited_q[nxt] <= 1'b1;
            on_path_q[nxt] <= 1'b1;
            depth_q        <= depth_q + wfgd_pkg::CntW'(1);
            state_q        <= D_READ;
          end else if (on_path_q[nxt]) begin
            state_q <= D_IDLE;
          end else begin
            state_q <= D_READ;
          end
        end
        default: state_q <= D_IDLE;
      endcase
    end
  end

endmodule

// ----- test/tb.sv -----
// Self-checking testbench of the wait-for graph deadlock detector with a graph predictor.
`timescale 1ns / 1ps

module tb;

  localparam int ClkHalf    = 6;
  localparam int WatchLimit = 4000;
  localparam int LongHold   = 300;
  localparam int PhaseCnt   = 22;
  localparam int PhaseItems = 28;
  localparam int HighNode   = 10;

  localparam logic ReqAdd   = 1'b0;
  localparam logic ReqCheck = 1'b1;

  typedef enum int {
    EdgeFwd,
    EdgeHigh,
    EdgeAny
  } edge_mode_e;

  typedef struct packed {
    logic            kind;
    wfgd_pkg::node_t src;
    wfgd_pkg::node_t dst;
  } wfg_req_t;

  logic       clk_i     = 1'b0;
  logic       rst_ni    = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  logic       req_type  = 1'b0;
  logic [3:0] from_node = '0;
  logic [3:0] to_node   = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] status;
  logic       cfg_we    = 1'b0;
  logic [4:0] cfg_wdata = '0;

  wfg_req_t          pend_q[$];
  wfgd_pkg::status_e status_q[$];

  wfgd_pkg::row_t graph_rows[wfgd_pkg::MaxNodes];
  wfgd_pkg::cnt_t node_count;

  logic in_taken     = 1'b0;
  logic no_idle      = 1'b0;
  int   send_gap     = 0;
  int   hold_left    = 0;
  int   stall_left   = 0;
  int   hold_reqs    = 0;
  int   holds_served = 0;
  int   quiet_cycles = 0;
  int   mismatch_cnt = 0;

  wait_for_graph_deadlock_detect_unit DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .req_type_i (req_type),
    .from_node_i(from_node),
    .to_node_i  (to_node),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .status_o   (status),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  always begin
    #ClkHalf clk_i = 1'b1;
    #ClkHalf clk_i = 1'b0;
  end

  function automatic int eff_nodes(input int count);
    return (count > wfgd_pkg::MaxNodes) ? wfgd_pkg::MaxNodes : count;
  endfunction

  function automatic wfgd_pkg::status_e predict_status(input wfg_req_t r);
    int              n;
    int              depth;
    int              top;
    int              v;
    int              i;
    logic            found;
    wfgd_pkg::row_t  visited;
    wfgd_pkg::row_t  on_path;
    wfgd_pkg::node_t stk_node[wfgd_pkg::MaxNodes];
    logic [4:0]      stk_next[wfgd_pkg::MaxNodes];
    n = eff_nodes(node_count);
    if (r.kind == ReqAdd) begin
      if (r.src >= n || r.dst >= n) begin
        return wfgd_pkg::StRejected;
      end
      graph_rows[r.src][r.dst] = 1'b1;
      return wfgd_pkg::StStored;
    end
    visited = '0;
    on_path = '0;
    depth   = 0;
    found   = 1'b0;
    for (int root = 0; root < n && !found; root++) begin
      if (!visited[root]) begin
        stk_node[0] = wfgd_pkg::node_t'(root);
        stk_next[0] = '0;
        depth = 1;
        visited[root] = 1'b1;
        on_path[root] = 1'b1;
        while (depth > 0 && !found) begin
          top = depth - 1;
          v = stk_node[top];
          i = stk_next[top];
          if (i >= n) begin
            on_path[v] = 1'b0;
            depth--;
          end else begin
            stk_next[top] = 5'(i + 1);
            if (graph_rows[v][i]) begin
              if (!visited[i]) begin
                stk_node[depth] = wfgd_pkg::node_t'(i);
                stk_next[depth] = '0;
                depth++;
                visited[i] = 1'b1;
                on_path[i] = 1'b1;
              end else if (on_path[i]) begin
                found = 1'b1;
              end
            end
          end
        end
      end
    end
    return found ? wfgd_pkg::StDeadlock : wfgd_pkg::StClear;
  endfunction

  function automatic int idle_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) begin
      return 0;
    end
    if (roll < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    mismatch_cnt++;
  endtask

  // Input beats leave the queue one at a time; valid holds until the beat is taken.
  always @(negedge clk_i) begin : drive_proc
    wfg_req_t nxt;
    if (rst_ni && !(in_valid && !in_taken)) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (pend_q.size() > 0) begin
        nxt = pend_q.pop_front();
        req_type  <= nxt.kind;
        from_node <= nxt.src;
        to_node   <= nxt.dst;
        in_valid  <= 1'b1;
        send_gap  <= no_idle ? 0 : idle_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin : recv_proc
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (holds_served < hold_reqs) begin
      holds_served <= holds_served + 1;
      hold_left    <= LongHold;
      out_ready    <= 1'b0;
    end else if (no_idle) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if ($urandom_range(0, 9) < 7) begin
      out_ready <= 1'b1;
    end else begin
      stall_left <= idle_gap();
      out_ready  <= 1'b0;
    end
  end

  always @(posedge clk_i) begin : mon_proc
    wfg_req_t          beat;
    wfgd_pkg::status_e want;
    if (!rst_ni) begin
      for (int k = 0; k < wfgd_pkg::MaxNodes; k++) begin
        graph_rows[k] = '0;
      end
      node_count = wfgd_pkg::cnt_t'(wfgd_pkg::MaxNodes);
      in_taken     <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      if (cfg_we) begin
        node_count = cfg_wdata;
      end
      if (out_valid && out_ready) begin
        if (status_q.size() == 0) begin
          report_mismatch("result beat with no request outstanding");
        end else begin
          want = status_q.pop_front();
          if (status !== want) begin
            report_mismatch($sformatf("status %0d, predicted %0d", status, want));
          end
        end
      end
      if (in_valid && in_ready) begin
        beat.kind = req_type;
        beat.src  = from_node;
        beat.dst  = to_node;
        status_q.push_back(predict_status(beat));
      end
      in_taken <= in_valid && in_ready;
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchLimit) begin
        $display("Mismatches found");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic wait_idle();
    while (pend_q.size() != 0 || in_valid || status_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_nodes(input logic [4:0] value);
    wait_idle();
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  task automatic push_req(input logic kind, input int src, input int dst);
    wfg_req_t r;
    r.kind = kind;
    r.src  = wfgd_pkg::node_t'(src);
    r.dst  = wfgd_pkg::node_t'(dst);
    pend_q.push_back(r);
  endtask

  // Edges that would close a cycle among low nodes are held back until the late phases.
  function automatic logic edge_ok(input int f, input int t, input int n, input edge_mode_e m);
    if (f >= n || t >= n) begin
      return 1'b1;
    end
    case (m)
      EdgeFwd:  return f < t;
      EdgeHigh: return (f < t) || (t >= HighNode);
      default:  return 1'b1;
    endcase
  endfunction

  task automatic push_random(input int n, input edge_mode_e m);
    int roll;
    int f;
    int t;
    roll = $urandom_range(0, 99);
    if (roll < 15) begin
      push_req(ReqCheck, $urandom_range(0, 15), $urandom_range(0, 15));
    end else begin
      do begin
        if (roll < 27 || n < 2) begin
          f = $urandom_range(0, 15);
          t = $urandom_range(0, 15);
        end else begin
          f = $urandom_range(0, n - 1);
          t = $urandom_range(0, n - 1);
        end
      end while (!edge_ok(f, t, n, m));
      push_req(ReqAdd, f, t);
    end
  endtask

  initial begin : stim_proc
    int         value;
    edge_mode_e mode;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    write_nodes(5'd16);
    push_req(ReqCheck, 0, 0);
    push_req(ReqAdd, 0, 1);
    push_req(ReqAdd, 1, 2);
    push_req(ReqAdd, 0, 15);
    push_req(ReqCheck, 15, 15);
    push_req(ReqAdd, 15, 15);
    push_req(ReqCheck, 0, 0);

    write_nodes(5'd15);
    push_req(ReqCheck, 0, 0);
    push_req(ReqAdd, 15, 0);
    push_req(ReqAdd, 0, 15);
    push_req(ReqAdd, 3, 4);
    push_req(ReqCheck, 0, 0);

    write_nodes(5'd0);
    push_req(ReqAdd, 0, 0);
    push_req(ReqCheck, 0, 0);

    write_nodes(5'd31);
    push_req(ReqAdd, 15, 14);
    push_req(ReqCheck, 0, 0);

    write_nodes(5'd1);
    push_req(ReqAdd, 0, 1);
    push_req(ReqAdd, 1, 0);
    push_req(ReqCheck, 0, 0);

    write_nodes(5'd17);
    push_req(ReqCheck, 0, 0);

    write_nodes(5'd2);
    push_req(ReqCheck, 0, 0);

    for (int p = 0; p < PhaseCnt; p++) begin
      case ($urandom_range(0, 9))
        0:       value = 0;
        1:       value = $urandom_range(17, 31);
        default: value = $urandom_range(1, 16);
      endcase
      mode = (p < 8) ? EdgeFwd : (p < 16) ? EdgeHigh : EdgeAny;
      write_nodes(value[4:0]);
      no_idle = (p % 5 == 3);
      if (p == 4) begin
        hold_reqs++;
      end
      for (int k = 0; k < PhaseItems; k++) begin
        push_random(eff_nodes(value), mode);
      end
    end

    wait_idle();
    repeat (20) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
